[sv/tcct_pkg.sv]
// Package for the ternary cube cover table: sizes, opcodes, request and
// result structs, controller state and command types. No dependencies.
package tcct_pkg;

	localparam int MAX_VARS    = 16;
	localparam int MAX_ENTRIES = 32;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NV_W        = 5;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [NV_W-1:0] NUM_VARS_RESET = NV_W'(16);

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] cube_value;
		logic [15:0] cube_dontcare;
	} tcct_req_t;

	typedef struct packed {
		logic       covered;
		logic       status;
		logic [5:0] entry_total;
	} tcct_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_REPLY
	} tcct_state_t;

	typedef struct packed {
		logic load;    // capture the request
		logic exec;    // compare against the table, update the table
		logic finish;  // reduce the match vector, drive the result
	} tcct_cmd_t;

endpackage

[sv/tcct_ctrl.sv]
// Controller of the ternary cube cover table: sequences one request through
// capture, match and reply. Depends on tcct_pkg.
module tcct_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output tcct_pkg::tcct_cmd_t   cmd
);

	tcct_pkg::tcct_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcct_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.exec   = 1'b0;
		cmd.finish = 1'b0;
		busy       = 1'b1;
		case (state_q)
			tcct_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = tcct_pkg::ST_MATCH;
				end
			end
			tcct_pkg::ST_MATCH: begin
				cmd.exec = 1'b1;
				state_d  = tcct_pkg::ST_REPLY;
			end
			tcct_pkg::ST_REPLY: begin
				cmd.finish = 1'b1;
				state_d    = tcct_pkg::ST_IDLE;
			end
			default: begin
				state_d = tcct_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[sv/tcct_dp.sv]
// Datapath of the ternary cube cover table: cube store, entry count,
// parallel per-entry compare, match reduction and result register.
// Depends on tcct_pkg.
module tcct_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcct_pkg::tcct_cmd_t           cmd,
	input  tcct_pkg::tcct_req_t           req,
	input  logic [tcct_pkg::NV_W-1:0]     num_vars,
	output logic                          done,
	output tcct_pkg::tcct_rsp_t           rsp
);

	localparam int NE = tcct_pkg::MAX_ENTRIES;
	localparam int NV = tcct_pkg::MAX_VARS;

	tcct_pkg::tcct_req_t               req_s1;
	logic [NV-1:0]                     val_q [NE];
	logic [NV-1:0]                     dc_q  [NE];
	logic [tcct_pkg::CNT_W-1:0]        count_q;
	logic [NE-1:0]                     match_s2;
	logic                              drop_s2;
	logic                              query_s2;
	logic                              done_q;
	tcct_pkg::tcct_rsp_t               rsp_q;

	logic [NV-1:0]                     var_mask;
	logic [NE-1:0]                     match_d;
	logic                              full;

	// Variables below num_vars take part; values above MAX_VARS saturate.
	always_comb begin
		for (int i = 0; i < NV; i++) begin
			var_mask[i] = (32'(i) < 32'(num_vars));
		end
	end

	assign full = (count_q == tcct_pkg::CNT_W'(NE));

	always_comb begin
		for (int e = 0; e < NE; e++) begin
			match_d[e] = (32'(e) < 32'(count_q)) &&
				((~dc_q[e] & (req_s1.cube_dontcare |
				(val_q[e] ^ req_s1.cube_value)) & var_mask) == '0);
		end
	end

	// Hold the request while it is in flight.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && req_s1.opcode == tcct_pkg::OP_ADD && !full) begin
			val_q[count_q[tcct_pkg::IDX_W-1:0]] <= req_s1.cube_value;
			dc_q[count_q[tcct_pkg::IDX_W-1:0]]  <= req_s1.cube_dontcare;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			match_s2 <= match_d;
			query_s2 <= (req_s1.opcode == tcct_pkg::OP_QUERY);
			drop_s2  <= (req_s1.opcode == tcct_pkg::OP_ADD) && full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			case (req_s1.opcode)
				tcct_pkg::OP_ADD: begin
					if (!full) begin
						count_q <= count_q + tcct_pkg::CNT_W'(1);
					end
				end
				tcct_pkg::OP_CLEAR: begin
					count_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.covered     <= query_s2 && (|match_s2);
			rsp_q.status      <= drop_s2;
			rsp_q.entry_total <= 6'(count_q);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[sv/ternary_cube_cover_table.sv]
// Top level of the ternary cube cover table: num_vars register, controller
// and datapath. Depends on tcct_pkg, tcct_ctrl and tcct_dp.
//
// Each request (add, query, clear) is taken when start is high and busy is
// low; busy then stays high through the match and reply steps, and the
// result appears on rsp from the result register with done high for exactly
// one cycle. A new request may be issued in the same cycle that done is
// shown, but none is taken while busy is high. Each request passes through
// the controller's three steps: capture, a registered compare of the query
// against every stored cube (up to 32) in parallel, and an OR reduction into
// the result register. The receiver cannot stall: sample rsp whenever done
// is high. An add to a full table (32 cubes) is dropped and reports status
// 1. Write num_vars only while busy is low and no result is pending; the
// value is used at compare time, and values above 16 count as 16.
module ternary_cube_cover_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  tcct_pkg::tcct_req_t   req,
	output logic                  done,
	output tcct_pkg::tcct_rsp_t   rsp,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_wdata
);

	logic [tcct_pkg::NV_W-1:0] num_vars_q;
	tcct_pkg::tcct_cmd_t       cmd;

	// Hold the variable count; reset to all sixteen variables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= tcct_pkg::NUM_VARS_RESET;
		end else if (cfg_we) begin
			num_vars_q <= cfg_wdata;
		end
	end

	tcct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	tcct_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req      (req),
		.num_vars (num_vars_q),
		.done     (done),
		.rsp      (rsp)
	);

endmodule

[sv/tcct_checker.sv]
// Port-level checker for the ternary cube cover table, bound to the top
// level. Depends on tcct_pkg and ternary_cube_cover_table.
module tcct_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input tcct_pkg::tcct_rsp_t   rsp
);

	// Every taken request is answered with a result on done.
	a_reply_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("request not answered on time");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.entry_total <= 6'(tcct_pkg::MAX_ENTRIES)))
		else $error("entry total out of range");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status) |->
		(rsp.entry_total == 6'(tcct_pkg::MAX_ENTRIES) && !rsp.covered))
		else $error("dropped add with table not full");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind ternary_cube_cover_table tcct_checker u_tcct_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
